FILE: rtl/bhh_pkg.sv
// Shared types and constants for the box hit hash table.
package bhh_pkg;

  localparam int TABLE_SIZE_DEF = 64;

  localparam logic [1:0] ACT_RECORD    = 2'd0;
  localparam logic [1:0] ACT_LOOKUP    = 2'd1;
  localparam logic [1:0] ACT_NEW_FRAME = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        key_id;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
  } item_t;

  typedef struct packed {
    logic               found;
    logic               hit;
    logic signed [15:0] found_x;
    logic signed [15:0] found_y;
    logic [14:0]        found_w;
    logic [14:0]        found_h;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] gen;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } entry_t;

  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_LOOKUP = 2'd1,
    RES_OVF    = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      probe_init;
    logic      probe_step;
    logic      write;
    logic      finish;
    res_kind_t res_kind;
    logic      clear_all;
    logic      sweep_init;
    logic      sweep_chk;
    logic      sweep_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_action;
    logic       in_key_zero;
    logic       is_record;
    logic       match;
    logic       empty;
    logic       last;
    logic       have_free;
    logic       fg_max;
    logic       idx_last;
  } sts_t;

endpackage

FILE: rtl/bhh_ctrl.sv
// Controller state machine: sequences probes, frame sweeps and result strobes.
module bhh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bhh_pkg::sts_t sts,
  output bhh_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_NEWF    = 6'b000010,
    ST_PRB_RD  = 6'b000100,
    ST_PRB_CMP = 6'b001000,
    ST_SWP_RD  = 6'b010000,
    ST_SWP_CMP = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_kind = bhh_pkg::RES_ZERO;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (sts.in_action == bhh_pkg::ACT_NEW_FRAME) begin
            cmd.load   = 1'b1;
            state_next = ST_NEWF;
          end else if ((sts.in_action == bhh_pkg::ACT_RECORD ||
                        sts.in_action == bhh_pkg::ACT_LOOKUP) && !sts.in_key_zero) begin
            cmd.load       = 1'b1;
            cmd.probe_init = 1'b1;
            state_next     = ST_PRB_RD;
          end else begin
            // id zero or unused code: answer with an all-zero word at once
            cmd.finish = 1'b1;
          end
        end
      end
      ST_NEWF: begin
        if (sts.fg_max) begin
          cmd.clear_all = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_SWP_RD;
        end
      end
      ST_PRB_RD: begin
        state_next = ST_PRB_CMP;
      end
      ST_PRB_CMP: begin
        if (sts.is_record) begin
          if (sts.match) begin
            cmd.write  = 1'b1;
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else if (sts.empty || sts.last) begin
            cmd.write    = sts.have_free;
            cmd.finish   = 1'b1;
            cmd.res_kind = sts.have_free ? bhh_pkg::RES_ZERO : bhh_pkg::RES_OVF;
            state_next   = ST_IDLE;
          end else begin
            cmd.probe_step = 1'b1;
            state_next     = ST_PRB_RD;
          end
        end else begin
          if (sts.match) begin
            cmd.finish   = 1'b1;
            cmd.res_kind = bhh_pkg::RES_LOOKUP;
            state_next   = ST_IDLE;
          end else if (sts.empty || sts.last) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.probe_step = 1'b1;
            state_next     = ST_PRB_RD;
          end
        end
      end
      ST_SWP_RD: begin
        state_next = ST_SWP_CMP;
      end
      ST_SWP_CMP: begin
        cmd.sweep_chk = 1'b1;
        if (sts.idx_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.sweep_step = 1'b1;
          state_next     = ST_SWP_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bhh_datapath.sv
// Datapath: slot memory, slot flags, probe index, generation and result register.
module bhh_datapath #(
  parameter int TABLE_SIZE = bhh_pkg::TABLE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  bhh_pkg::item_t   item,
  input  bhh_pkg::cmd_t    cmd,
  output bhh_pkg::sts_t    sts,
  output bhh_pkg::result_t result,
  output logic             strobe
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam logic [IW:0]   SIZE_W   = (IW+1)'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  bhh_pkg::item_t  item_q;
  bhh_pkg::entry_t mem [TABLE_SIZE];
  bhh_pkg::entry_t rd_q;
  bhh_pkg::entry_t wdata;

  logic [TABLE_SIZE-1:0] live;
  logic [TABLE_SIZE-1:0] used;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_inc;
  logic [IW-1:0]         count;
  logic [IW-1:0]         free_idx;
  logic                  free_vld;
  logic [IW-1:0]         w_idx;
  logic [IW-1:0]         raw_start;
  logic [IW-1:0]         start_idx;
  logic [31:0]           fg;
  logic [31:0]           gen_inc;
  logic                  gen_prev;
  logic                  cur_free;
  logic                  inside_box;
  logic signed [16:0]    bx_e;
  logic signed [16:0]    by_e;
  logic signed [16:0]    rx_e;
  logic signed [16:0]    ry_e;
  logic signed [16:0]    px_e;
  logic signed [16:0]    py_e;
  bhh_pkg::result_t      res_next;

  // Start slot: low key bits folded once into range; any slot works as long as the lap is full.
  assign raw_start = item.key_id[IW-1:0];
  assign start_idx = ({1'b0, raw_start} >= SIZE_W) ? raw_start - SIZE_W[IW-1:0] : raw_start;
  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  assign cur_free = !live[idx];
  assign w_idx    = (sts.match || !free_vld) ? idx : free_idx;
  assign gen_inc  = rd_q.gen + 32'd1;
  assign gen_prev = (gen_inc == fg);

  assign sts.in_action   = item.action;
  assign sts.in_key_zero = (item.key_id == 32'd0);
  assign sts.is_record   = (item_q.action == bhh_pkg::ACT_RECORD);
  assign sts.match       = live[idx] && (rd_q.key == item_q.key_id);
  assign sts.empty       = !used[idx];
  assign sts.last        = (count == LAST_IDX);
  assign sts.have_free   = free_vld || cur_free;
  assign sts.fg_max      = (fg == 32'hFFFF_FFFF);
  assign sts.idx_last    = (idx == LAST_IDX);

  always_comb begin
    wdata     = '0;
    wdata.key = item_q.key_id;
    wdata.gen = fg;
    wdata.x   = item_q.box_x;
    wdata.y   = item_q.box_y;
    wdata.w   = item_q.box_w;
    wdata.h   = item_q.box_h;
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[w_idx] <= wdata;
    end
    rd_q <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      count    <= '0;
      free_vld <= 1'b0;
      free_idx <= '0;
    end else begin
      if (cmd.probe_init) begin
        idx      <= start_idx;
        count    <= '0;
        free_vld <= 1'b0;
      end else if (cmd.probe_step) begin
        idx   <= idx_inc;
        count <= count + 1'b1;
        // remember the first reusable slot on the way
        if (cur_free && !free_vld) begin
          free_vld <= 1'b1;
          free_idx <= idx;
        end
      end else if (cmd.sweep_init) begin
        idx <= '0;
      end else if (cmd.sweep_step) begin
        idx <= idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= '0;
    end else if (cmd.clear_all) begin
      fg <= 32'd1;
    end else if (cmd.sweep_init) begin
      fg <= fg + 32'd1;
    end
  end

  // Dropped entries stay as used-but-dead slots so probe chains remain intact.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      live <= '0;
      used <= '0;
    end else begin
      if (cmd.write) begin
        live[w_idx] <= 1'b1;
        used[w_idx] <= 1'b1;
      end
      if (cmd.sweep_chk && live[idx] && !gen_prev) begin
        live[idx] <= 1'b0;
      end
    end
  end

  assign bx_e = {rd_q.x[15], rd_q.x};
  assign by_e = {rd_q.y[15], rd_q.y};
  assign rx_e = bx_e + $signed({2'b00, rd_q.w});
  assign ry_e = by_e + $signed({2'b00, rd_q.h});
  assign px_e = {item_q.cursor_x[15], item_q.cursor_x};
  assign py_e = {item_q.cursor_y[15], item_q.cursor_y};
  assign inside_box = (px_e >= bx_e) && (py_e >= by_e) && (px_e <= rx_e) && (py_e <= ry_e);

  always_comb begin
    res_next = '0;
    case (cmd.res_kind)
      bhh_pkg::RES_LOOKUP: begin
        if (gen_prev) begin
          res_next.found   = 1'b1;
          res_next.hit     = inside_box;
          res_next.found_x = rd_q.x;
          res_next.found_y = rd_q.y;
          res_next.found_w = rd_q.w;
          res_next.found_h = rd_q.h;
        end
      end
      bhh_pkg::RES_OVF: begin
        res_next.overflow = 1'b1;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.finish;
    end
  end

endmodule

FILE: rtl/box_hit_hash_table_unit.sv
// Top level of the box hit hash table: controller, datapath and checks.
//
// Give a word on item while start is high and busy is low; the answer shows on
// result for one cycle with strobe high and cannot be held off, so sample it then.
// Each probe of a slot is a registered read of the slot memory followed by a compare,
// and busy stays high while a record or lookup probes its slots; a new item may
// follow once busy is low again, and the answer is registered from the last compare.
// A record or lookup with id zero, or an unused action code, answers straight
// from idle and leaves busy low. A new frame walks every slot, with busy high,
// to drop entries not from the frame that ended, or passes only the ST_NEWF state
// when the generation wraps and the whole table is emptied.
module box_hit_hash_table_unit #(
  parameter int TABLE_SIZE = bhh_pkg::TABLE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bhh_pkg::item_t   item,
  output bhh_pkg::result_t result,
  output logic             strobe
);

  bhh_pkg::cmd_t cmd;
  bhh_pkg::sts_t sts;

  bhh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bhh_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result),
    .strobe (strobe)
  );

  a_probe_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.key_id != 32'd0 &&
     (item.action == bhh_pkg::ACT_RECORD || item.action == bhh_pkg::ACT_LOOKUP)) |=> busy)
    else $error("probe word accepted without going busy");

  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe with no word in progress");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  a_ovf_probe: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.overflow) |-> (!result.found && $past(busy)))
    else $error("overflow reported outside a record probe");

endmodule
